// ===== rtl/swr_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step and wrist rotation detector package
// Shared constants, register map, configuration bundle and the command
// bundle that the controller drives into the datapath.
// ----------------------------------------------------------------------------
package swr_pkg;

    // Fixed-point and state widths.
    localparam int FRAC_BITS   = 8;
    localparam int ANGLE_WIDTH = 32;
    localparam int COUNT_WIDTH = 32;

    // Width of the filter accumulator: 16 integer bits plus the fraction.
    localparam int FV_W = 16 + FRAC_BITS;

    // Sequencing lengths of the iterative units.
    localparam int SQ_COUNT   = 3;
    localparam int ROOT_STEPS = 16;
    localparam int DIV_STEPS  = FV_W;
    localparam int CNT_W      = $clog2(DIV_STEPS);

    // Configuration port address width (six 32-bit registers).
    localparam int ADDR_W = 5;

    // Register indexes.
    typedef enum logic [2:0] {
        REG_REST_MAGNITUDE   = 3'd0,
        REG_FILTER_DIVISOR   = 3'd1,
        REG_STEP_HIGH_OFFSET = 3'd2,
        REG_STEP_LOW_OFFSET  = 3'd3,
        REG_RATE_THRESHOLD   = 3'd4,
        REG_ANGLE_THRESHOLD  = 3'd5
    } reg_idx_t;

    // Reset values of the registers.
    localparam logic [15:0]        RST_REST_MAGNITUDE   = 16'd4096;
    localparam logic [7:0]         RST_FILTER_DIVISOR   = 8'd8;
    localparam logic signed [15:0] RST_STEP_HIGH_OFFSET = 16'sd1000;
    localparam logic signed [15:0] RST_STEP_LOW_OFFSET  = 16'sd500;
    localparam logic [15:0]        RST_RATE_THRESHOLD   = 16'd2000;
    localparam logic [30:0]        RST_ANGLE_THRESHOLD  = 31'd100000;

    // Current register contents plus the filter reload request.
    typedef struct packed {
        logic [15:0]        rest_magnitude;
        logic [7:0]         filter_divisor;
        logic signed [15:0] step_high_offset;
        logic signed [15:0] step_low_offset;
        logic [15:0]        rate_threshold;
        logic [30:0]        angle_threshold;
        logic               rest_load;
        logic [15:0]        rest_load_value;
    } cfg_t;

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic       load_in;
        logic       sq_first;
        logic [1:0] sq_sel;
        logic       root_init;
        logic       root_step;
        logic       div_init;
        logic       div_step;
        logic       commit;
    } cmd_t;

    // Operand selects of the shared squaring multiplier.
    localparam logic [1:0] SQ_SEL_X = 2'd0;
    localparam logic [1:0] SQ_SEL_Y = 2'd1;
    localparam logic [1:0] SQ_SEL_Z = 2'd2;

endpackage

// ===== rtl/swr_regs.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Configuration register file
// APB-style write and read access to the six detector registers. A write
// to the rest magnitude also requests a reload of the filter.
// ----------------------------------------------------------------------------
module swr_regs
    import swr_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              psel,
    input  logic              penable,
    input  logic              pwrite,
    input  logic [ADDR_W-1:0] paddr,
    input  logic [31:0]       pwdata,
    output logic [31:0]       prdata,
    output logic              pready,
    output cfg_t              cfg
);

    logic [15:0]        rest_reg;
    logic [7:0]         smooth_reg;
    logic signed [15:0] high_reg;
    logic signed [15:0] low_reg;
    logic [15:0]        rate_reg;
    logic [30:0]        angle_thr_reg;
    logic               wr_en;
    reg_idx_t           idx;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite;
    assign idx    = reg_idx_t'(paddr[ADDR_W-1:2]);

    // Register writes; an index beyond the map is ignored.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rest_reg      <= RST_REST_MAGNITUDE;
            smooth_reg    <= RST_FILTER_DIVISOR;
            high_reg      <= RST_STEP_HIGH_OFFSET;
            low_reg       <= RST_STEP_LOW_OFFSET;
            rate_reg      <= RST_RATE_THRESHOLD;
            angle_thr_reg <= RST_ANGLE_THRESHOLD;
        end
        else if (wr_en)
        begin
            case (idx)
                REG_REST_MAGNITUDE:   rest_reg      <= pwdata[15:0];
                REG_FILTER_DIVISOR:   smooth_reg    <= pwdata[7:0];
                REG_STEP_HIGH_OFFSET: high_reg      <= signed'(pwdata[15:0]);
                REG_STEP_LOW_OFFSET:  low_reg       <= signed'(pwdata[15:0]);
                REG_RATE_THRESHOLD:   rate_reg      <= pwdata[15:0];
                REG_ANGLE_THRESHOLD:  angle_thr_reg <= pwdata[30:0];
                default:              ;
            endcase
        end
    end

    // Read mux; signed offsets read back sign-extended.
    always_comb
    begin
        case (idx)
            REG_REST_MAGNITUDE:   prdata = {16'd0, rest_reg};
            REG_FILTER_DIVISOR:   prdata = {24'd0, smooth_reg};
            REG_STEP_HIGH_OFFSET: prdata = {{16{high_reg[15]}}, high_reg};
            REG_STEP_LOW_OFFSET:  prdata = {{16{low_reg[15]}}, low_reg};
            REG_RATE_THRESHOLD:   prdata = {16'd0, rate_reg};
            REG_ANGLE_THRESHOLD:  prdata = {1'b0, angle_thr_reg};
            default:              prdata = 32'd0;
        endcase
    end

    assign cfg.rest_magnitude   = rest_reg;
    assign cfg.filter_divisor   = smooth_reg;
    assign cfg.step_high_offset = high_reg;
    assign cfg.step_low_offset  = low_reg;
    assign cfg.rate_threshold   = rate_reg;
    assign cfg.angle_threshold  = angle_thr_reg;
    assign cfg.rest_load        = wr_en && (idx == REG_REST_MAGNITUDE);
    assign cfg.rest_load_value  = pwdata[15:0];

endmodule

// ===== rtl/swr_ctrl.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector controller
// Sequences one sample through squaring, square root, filter division and
// the final state update, and owns the input and output handshakes.
// ----------------------------------------------------------------------------
module swr_ctrl
    import swr_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic in_valid,
    output logic in_ready,
    output logic out_valid,
    input  logic out_ready,
    output cmd_t cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SQUARE,
        S_ROOT,
        S_DIV_INIT,
        S_DIVIDE,
        S_COMMIT
    } state_t;

    state_t           state_reg;
    logic [CNT_W-1:0] cnt_reg;
    logic             out_valid_reg;
    logic             out_free;

    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;
    assign out_free  = !out_valid_reg || out_ready;

    // Commands decoded from the current state and step count.
    always_comb
    begin
        cmd = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                cmd.load_in = in_valid;
            end
            S_SQUARE:
            begin
                cmd.sq_first  = (cnt_reg == '0);
                cmd.sq_sel    = cnt_reg[1:0];
                cmd.root_init = (cnt_reg == CNT_W'(SQ_COUNT - 1));
            end
            S_ROOT:
            begin
                cmd.root_step = 1'b1;
            end
            S_DIV_INIT:
            begin
                cmd.div_init = 1'b1;
            end
            S_DIVIDE:
            begin
                cmd.div_step = 1'b1;
            end
            S_COMMIT:
            begin
                cmd.commit = out_free;
            end
        endcase
    end

    // State, step counter and output valid flag.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            // The result flag rises on a commit and falls when the beat is taken.
            if ((state_reg == S_COMMIT) && out_free)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_valid_reg && out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
            unique case (state_reg)
                S_IDLE:
                begin
                    cnt_reg <= '0;
                    if (in_valid)
                    begin
                        state_reg <= S_SQUARE;
                    end
                end
                S_SQUARE:
                begin
                    if (cnt_reg == CNT_W'(SQ_COUNT - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_ROOT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_ROOT:
                begin
                    if (cnt_reg == CNT_W'(ROOT_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_DIV_INIT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_DIV_INIT:
                begin
                    cnt_reg   <= '0;
                    state_reg <= S_DIVIDE;
                end
                S_DIVIDE:
                begin
                    if (cnt_reg == CNT_W'(DIV_STEPS - 1))
                    begin
                        cnt_reg   <= '0;
                        state_reg <= S_COMMIT;
                    end
                    else
                    begin
                        cnt_reg <= cnt_reg + 1'b1;
                    end
                end
                S_COMMIT:
                begin
                    // Wait here while the previous result is still unread.
                    if (out_free)
                    begin
                        state_reg <= S_IDLE;
                    end
                end
            endcase
        end
    end

endmodule

// ===== rtl/swr_dp.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector datapath
// Shared squaring multiplier, bit-pair square root, restoring divider for
// the filter step, and the hysteresis, angle and step count state.
// ----------------------------------------------------------------------------
module swr_dp
    import swr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  cmd_t               cmd,
    input  cfg_t               cfg,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    output logic               step_detected,
    output logic               wrist_detected,
    output logic [31:0]        steps_total,
    output logic [15:0]        filtered_magnitude
);

    localparam int AW   = ANGLE_WIDTH;
    localparam int AC_W = (ANGLE_WIDTH > 31) ? ANGLE_WIDTH : 31;

    // Sample registers.
    logic signed [15:0] ax_reg, ay_reg, az_reg, gx_reg;

    // Squaring and root registers.
    logic [31:0] acc_reg;
    logic [31:0] rem_reg;
    logic [31:0] root_reg;
    logic [31:0] bit_reg;

    // Divider registers.
    logic [FV_W-1:0] num_reg;
    logic [7:0]      drem_reg;
    logic [7:0]      divisor_reg;
    logic            neg_reg;

    // Detector state.
    logic [FV_W-1:0]        fv_reg;
    logic                   stride_reg;
    logic [AW-1:0]          angle_reg;
    logic [COUNT_WIDTH-1:0] count_reg;

    // Result registers.
    logic        step_reg;
    logic        wrist_reg;
    logic [31:0] total_reg;
    logic [15:0] filt_reg;

    // Combinational terms.
    logic signed [15:0] sq_op;
    logic signed [31:0] sq_prod;
    logic [31:0]        sq_sum;
    logic [32:0]        trial;
    logic               root_ge;
    logic [FV_W-1:0]    mag_fx;
    logic signed [FV_W:0] diff;
    logic [FV_W:0]      diff_abs;
    logic [8:0]         div_shift;
    logic               div_ge;
    logic [8:0]         div_sub;
    logic signed [FV_W:0] q_s;
    logic [FV_W:0]      fv_sum;
    logic [FV_W-1:0]    fv_new;
    logic [15:0]        filt;
    logic signed [17:0] filt_s;
    logic signed [17:0] hi_thr;
    logic signed [17:0] lo_thr;
    logic               step;
    logic               stride_new;
    logic signed [AW:0] a_sum;
    logic [AW-1:0]      a_sat;
    logic [AW-1:0]      a_abs;
    logic [15:0]        g_abs;
    logic               wrist;
    logic [COUNT_WIDTH-1:0] count_new;

    // Shared squaring multiplier; the sum of squares stays below 2^32.
    always_comb
    begin
        case (cmd.sq_sel)
            SQ_SEL_X: sq_op = ax_reg;
            SQ_SEL_Y: sq_op = ay_reg;
            SQ_SEL_Z: sq_op = az_reg;
            default:  sq_op = ax_reg;
        endcase
    end

    assign sq_prod = sq_op * sq_op;
    assign sq_sum  = (cmd.sq_first ? 32'd0 : acc_reg) + $unsigned(sq_prod);

    // One bit pair of the integer square root per cycle.
    assign trial   = {1'b0, root_reg} + {1'b0, bit_reg};
    assign root_ge = ({1'b0, rem_reg} >= trial);

    // Filter difference and its magnitude for the unsigned divider.
    assign mag_fx   = FV_W'(root_reg[15:0]) << FRAC_BITS;
    assign diff     = $signed({1'b0, mag_fx}) - $signed({1'b0, fv_reg});
    assign diff_abs = diff[FV_W] ? $unsigned(-diff) : $unsigned(diff);

    // One quotient bit per cycle of the restoring divider.
    assign div_shift = {drem_reg, num_reg[FV_W-1]};
    assign div_ge    = (div_shift >= {1'b0, divisor_reg});
    assign div_sub   = div_shift - {1'b0, divisor_reg};

    // Filter update with the quotient truncated toward zero.
    assign q_s    = neg_reg ? -$signed({1'b0, num_reg}) : $signed({1'b0, num_reg});
    assign fv_sum = {1'b0, fv_reg} + $unsigned(q_s);
    assign fv_new = fv_sum[FV_W-1:0];
    assign filt   = fv_new[FV_W-1 -: 16];

    // Step hysteresis against rest plus the signed offsets.
    assign filt_s = $signed({2'b00, filt});
    assign hi_thr = $signed({2'b00, cfg.rest_magnitude})
                  + $signed({{2{cfg.step_high_offset[15]}}, cfg.step_high_offset});
    assign lo_thr = $signed({2'b00, cfg.rest_magnitude})
                  + $signed({{2{cfg.step_low_offset[15]}}, cfg.step_low_offset});

    always_comb
    begin
        step       = 1'b0;
        stride_new = stride_reg;
        if (!stride_reg && (filt_s > hi_thr))
        begin
            step       = 1'b1;
            stride_new = 1'b1;
        end
        else if (stride_reg && (filt_s < lo_thr))
        begin
            stride_new = 1'b0;
        end
    end

    // Saturating angle sum and wrist rotation test.
    assign a_sum = $signed({angle_reg[AW-1], angle_reg})
                 + $signed({{(AW + 1 - 16){gx_reg[15]}}, gx_reg});
    assign a_sat = (a_sum[AW] != a_sum[AW-1])
                 ? {a_sum[AW], {(AW - 1){~a_sum[AW]}}}
                 : a_sum[AW-1:0];
    assign a_abs = a_sat[AW-1] ? (~a_sat + 1'b1) : a_sat;
    assign g_abs = gx_reg[15] ? $unsigned(~gx_reg + 16'd1) : $unsigned(gx_reg);
    assign wrist = (g_abs > cfg.rate_threshold)
                && (AC_W'(a_abs) >= AC_W'(cfg.angle_threshold));

    assign count_new = (step && !wrist) ? count_reg + 1'b1 : count_reg;

    // Working registers of the sample, root and divider.
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            ax_reg <= accel_x;
            ay_reg <= accel_y;
            az_reg <= accel_z;
            gx_reg <= gyro_x;
        end
        if (cmd.sq_sel != SQ_SEL_X || cmd.sq_first)
        begin
            acc_reg <= sq_sum;
        end
        if (cmd.root_init)
        begin
            rem_reg  <= sq_sum;
            root_reg <= 32'd0;
            bit_reg  <= 32'h4000_0000;
        end
        else if (cmd.root_step)
        begin
            if (root_ge)
            begin
                rem_reg  <= rem_reg - trial[31:0];
                root_reg <= (root_reg >> 1) + bit_reg;
            end
            else
            begin
                root_reg <= root_reg >> 1;
            end
            bit_reg <= bit_reg >> 2;
        end
        if (cmd.div_init)
        begin
            num_reg     <= diff_abs[FV_W-1:0];
            neg_reg     <= diff[FV_W];
            drem_reg    <= 8'd0;
            divisor_reg <= (cfg.filter_divisor == 8'd0) ? 8'd1 : cfg.filter_divisor;
        end
        else if (cmd.div_step)
        begin
            drem_reg <= div_ge ? div_sub[7:0] : div_shift[7:0];
            num_reg  <= {num_reg[FV_W-2:0], div_ge};
        end
        if (cmd.commit)
        begin
            step_reg  <= step;
            wrist_reg <= wrist;
            total_reg <= 32'(count_new);
            filt_reg  <= filt;
        end
    end

    // Detector state, reset to its defaults; a rest write reloads the filter.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fv_reg     <= FV_W'(RST_REST_MAGNITUDE) << FRAC_BITS;
            stride_reg <= 1'b0;
            angle_reg  <= '0;
            count_reg  <= '0;
        end
        else if (cfg.rest_load)
        begin
            fv_reg <= FV_W'(cfg.rest_load_value) << FRAC_BITS;
        end
        else if (cmd.commit)
        begin
            fv_reg     <= fv_new;
            stride_reg <= stride_new;
            angle_reg  <= wrist ? '0 : a_sat;
            count_reg  <= count_new;
        end
    end

    assign step_detected      = step_reg;
    assign wrist_detected     = wrist_reg;
    assign steps_total        = total_reg;
    assign filtered_magnitude = filt_reg;

endmodule

// ===== rtl/step_and_wrist_rotation_detector.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Step and wrist rotation detector
// Pedometer on accelerometer magnitude with wrist rotation rejection.
// ----------------------------------------------------------------------------
// Usage:
// A sample beat (accel_x/y/z, gyro_x) is taken on in_valid && in_ready. One
// result beat (step_detected, wrist_detected, steps_total,
// filtered_magnitude) follows each sample on out_valid && out_ready.
// After the sample is accepted, out_valid rises once it has passed through
// the squaring of each axis on the shared multiplier, 16 root iterations,
// a divider setup step, 24 divider iterations and a commit step.
// in_ready is high only while the block is idle; it stays high with a
// result still waiting, and the next sample starts at once.
// If the receiver stalls, the finished result is held in the output
// register and a later sample waits in its commit cycle until that beat
// is taken; the state is updated only when the result is handed over.
// Reset clears the registers to their defaults, loads the filter with the
// rest magnitude and clears the stride flag, angle and step count.
// The user writes the registers over the APB-style port while the block is
// idle; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module step_and_wrist_rotation_detector
    import swr_pkg::*;
(
    input  logic               clk,
    input  logic               rst_n,
    input  logic               psel,
    input  logic               penable,
    input  logic               pwrite,
    input  logic [ADDR_W-1:0]  paddr,
    input  logic [31:0]        pwdata,
    output logic [31:0]        prdata,
    output logic               pready,
    input  logic               in_valid,
    output logic               in_ready,
    input  logic signed [15:0] accel_x,
    input  logic signed [15:0] accel_y,
    input  logic signed [15:0] accel_z,
    input  logic signed [15:0] gyro_x,
    output logic               out_valid,
    input  logic               out_ready,
    output logic               step_detected,
    output logic               wrist_detected,
    output logic [31:0]        steps_total,
    output logic [15:0]        filtered_magnitude
);

    cfg_t cfg;
    cmd_t cmd;

    swr_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    swr_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .cmd       (cmd)
    );

    swr_dp u_dp (
        .clk                (clk),
        .rst_n              (rst_n),
        .cmd                (cmd),
        .cfg                (cfg),
        .accel_x            (accel_x),
        .accel_y            (accel_y),
        .accel_z            (accel_z),
        .gyro_x             (gyro_x),
        .step_detected      (step_detected),
        .wrist_detected     (wrist_detected),
        .steps_total        (steps_total),
        .filtered_magnitude (filtered_magnitude)
    );

endmodule

// ===== rtl/swr_checker.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Detector port checker
// Watches the top-level handshakes for sequencing and hold behavior.
// ----------------------------------------------------------------------------
module swr_checker
    import swr_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic        step_detected,
    input logic        wrist_detected,
    input logic [31:0] steps_total,
    input logic [15:0] filtered_magnitude
);

    localparam int LATENCY = SQ_COUNT + ROOT_STEPS + 1 + DIV_STEPS + 1;

    // A stalled result beat holds its value.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(steps_total)
            && $stable(filtered_magnitude) && $stable(step_detected)
            && $stable(wrist_detected))
    else $error("stalled result beat changed");

    // The block is busy right after taking a sample.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
    else $error("sample accepted while still busy");

    // An idle block with no sample offered stays ready.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_ready && !in_valid |=> in_ready)
    else $error("idle block dropped ready");

    // A result is visible on the edge after the commit cycle.
    assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |-> ##(LATENCY + 1) out_valid)
    else $error("result missing after sample latency");

endmodule

bind step_and_wrist_rotation_detector swr_checker u_swr_checker (.*);
